>>> rtl/core/quadrature_gain_phase_detector_unit_defines.svh
// Assertion macros used by the checker file of the detector.
`ifndef QUADRATURE_GAIN_PHASE_DETECTOR_UNIT_DEFINES_SVH
`define QUADRATURE_GAIN_PHASE_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define QGPD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("detector port check failed");

// Next-cycle implication.
`define QGPD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("detector port check failed");

`endif

>>> rtl/core/qgpd_pkg.sv
// Shared constants, types and the sine table generator of the detector.
`default_nettype none
package qgpd_pkg;

    localparam int QUEUE_DEPTH     = 2;
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int LOG_FRAC_BITS   = 16;
    localparam int GAIN_MAX_Q8     = 24576;
    localparam int LOG_SCALE       = 197283;
    localparam int PHASE_SCALE     = 46080;
    localparam int CORDIC_GAIN_Q30 = 652032874;
    localparam int ATAN_ENTRIES    = 24;

    // Angle of atan(2^-i) in 2^32 per turn.
    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_START,
        B_NORM,
        B_SQUARE,
        B_GAIN,
        B_GSAT,
        B_CPREP,
        B_CITER,
        B_CEND,
        B_PHASE,
        B_PFIN,
        B_DONE
    } back_state_t;

    // One sine table entry, Q1.15, by CORDIC rotation; evaluated at elaboration.
    function automatic logic signed [15:0] sine_entry(input int k, input int tbits,
                                                       input int steps);
        longint a;
        longint x;
        longint y;
        longint z;
        longint nx;
        longint v;
        logic   neg;
        a   = longint'(k) << (32 - tbits);
        neg = 1'b0;
        x   = longint'(CORDIC_GAIN_Q30);
        y   = 0;
        if (((a >> 30) == 1) || ((a >> 30) == 2)) begin
            a   = (a + 64'sh80000000) & 64'shFFFFFFFF;
            neg = 1'b1;
        end
        z = (a >= 64'sh80000000) ? a - 64'sh100000000 : a;
        for (int i = 0; i < steps; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'({32'b0, ATAN_TURNS[i]});
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'({32'b0, ATAN_TURNS[i]});
            end
            x = nx;
        end
        v = (y + 16384) >>> 15;
        if (neg) begin
            v = -v;
        end
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32767) begin
            v = -32767;
        end
        return 16'(v);
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/qgpd_front.sv
// Front end: sample intake, oscillator, table lookup and correlation accumulators.
`default_nettype none
module qgpd_front #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int MAX_COUNT_BITS  = 16,
    parameter int CORDIC_STEPS    = 16,
    localparam int ACC_W          = MAX_COUNT_BITS + 32,
    localparam int SNAP_W         = 6 * ACC_W + 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic signed [15:0]           ref_sample,
    input  wire logic signed [15:0]           dut_sample,
    input  wire logic                         last_sample,
    input  wire logic                         step_we,
    input  wire logic [31:0]                  step_wdata,
    input  wire qgpd_pkg::queue_status_t      qstat,
    output logic                              snap_push,
    output logic [SNAP_W-1:0]                 snap_data
);

    localparam int TABLE_SIZE  = 1 << SINE_TABLE_BITS;
    localparam int QUARTER     = TABLE_SIZE / 4;
    localparam int MAX_SAMPLES = 1 << MAX_COUNT_BITS;
    localparam int CNT_W       = MAX_COUNT_BITS + 1;

    logic signed [15:0] sine_rom [TABLE_SIZE];

    for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_rom
        assign sine_rom[k] = qgpd_pkg::sine_entry(k, SINE_TABLE_BITS, CORDIC_STEPS);
    end

    logic [31:0]                step_reg;
    logic [31:0]                nco_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_inc;
    logic [SINE_TABLE_BITS-1:0] sin_idx;
    logic [SINE_TABLE_BITS-1:0] cos_idx;
    logic                       accept;

    logic                       v1_reg, l1_reg, v2_reg, l2_reg;
    logic signed [15:0]         r1_reg, d1_reg, sin1_reg, cos1_reg;
    logic                       use1_reg, ovf1_reg, ovf2_reg;
    logic signed [31:0]         prr_reg, pdd_reg, pri_reg, prq_reg, pdi_reg, pdq_reg;

    logic signed [ACC_W-1:0]    are_reg, ade_reg, ari_reg, arq_reg, adi_reg, adq_reg;
    logic signed [ACC_W-1:0]    sre, sde, sri, srq, sdi, sdq;
    logic [2:0]                 pending;

    // Hold intake while the queue could not take every block end already in flight.
    assign pending = {1'b0, qstat.count} + 3'(l1_reg) + 3'(l2_reg);
    assign full    = (pending >= 3'(qgpd_pkg::QUEUE_DEPTH));
    assign accept  = push & ~full;

    assign sin_idx = nco_reg[31 -: SINE_TABLE_BITS];
    assign cos_idx = sin_idx + SINE_TABLE_BITS'(QUARTER);
    assign cnt_inc = (cnt_reg <= CNT_W'(MAX_SAMPLES)) ? cnt_reg + CNT_W'(1) : cnt_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            step_reg <= '0;
        end else if (step_we) begin
            step_reg <= step_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            nco_reg <= '0;
            cnt_reg <= '0;
            v1_reg  <= 1'b0;
            l1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            l2_reg  <= 1'b0;
        end else begin
            v1_reg <= accept;
            l1_reg <= accept & last_sample;
            v2_reg <= v1_reg;
            l2_reg <= l1_reg;
            if (accept) begin
                if (last_sample) begin
                    nco_reg <= '0;
                    cnt_reg <= '0;
                end else begin
                    nco_reg <= nco_reg + step_reg;
                    cnt_reg <= cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            r1_reg   <= ref_sample;
            d1_reg   <= dut_sample;
            sin1_reg <= sine_rom[sin_idx];
            cos1_reg <= sine_rom[cos_idx];
            use1_reg <= (cnt_reg < CNT_W'(MAX_SAMPLES));
            ovf1_reg <= (cnt_inc > CNT_W'(MAX_SAMPLES));
        end
        if (v1_reg) begin
            prr_reg  <= use1_reg ? r1_reg * r1_reg   : 32'sd0;
            pdd_reg  <= use1_reg ? d1_reg * d1_reg   : 32'sd0;
            pri_reg  <= use1_reg ? r1_reg * cos1_reg : 32'sd0;
            prq_reg  <= use1_reg ? r1_reg * sin1_reg : 32'sd0;
            pdi_reg  <= use1_reg ? d1_reg * cos1_reg : 32'sd0;
            pdq_reg  <= use1_reg ? d1_reg * sin1_reg : 32'sd0;
            ovf2_reg <= ovf1_reg;
        end
    end

    assign sre = are_reg + ACC_W'(prr_reg);
    assign sde = ade_reg + ACC_W'(pdd_reg);
    assign sri = ari_reg + ACC_W'(pri_reg);
    assign srq = arq_reg + ACC_W'(prq_reg);
    assign sdi = adi_reg + ACC_W'(pdi_reg);
    assign sdq = adq_reg + ACC_W'(pdq_reg);

    // Advance the sums; on a block end hand them to the queue and clear.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            are_reg <= '0;
            ade_reg <= '0;
            ari_reg <= '0;
            arq_reg <= '0;
            adi_reg <= '0;
            adq_reg <= '0;
        end else if (v2_reg) begin
            if (l2_reg) begin
                are_reg <= '0;
                ade_reg <= '0;
                ari_reg <= '0;
                arq_reg <= '0;
                adi_reg <= '0;
                adq_reg <= '0;
            end else begin
                are_reg <= sre;
                ade_reg <= sde;
                ari_reg <= sri;
                arq_reg <= srq;
                adi_reg <= sdi;
                adq_reg <= sdq;
            end
        end
    end

    assign snap_push = v2_reg & l2_reg;
    assign snap_data = {ovf2_reg, sre, sde, sri, srq, sdi, sdq};

endmodule
`default_nettype wire

>>> rtl/core/qgpd_queue.sv
// Small queue of block snapshots between front and back end.
`default_nettype none
module qgpd_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    wr_en,
    input  wire logic [WIDTH-1:0]        wr_data,
    input  wire logic                    rd_en,
    output logic [WIDTH-1:0]             rd_data,
    output qgpd_pkg::queue_status_t      qstat
);

    localparam int DEPTH = qgpd_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    logic [WIDTH-1:0]                mem [DEPTH];
    logic [PW-1:0]                   wp_reg, rp_reg;
    logic [qgpd_pkg::QCNT_W-1:0]     cnt_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) begin
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
            end
            if (rd_en) begin
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
            end
            cnt_reg <= cnt_reg + qgpd_pkg::QCNT_W'(wr_en) - qgpd_pkg::QCNT_W'(rd_en);
        end
    end

    assign rd_data     = mem[rp_reg];
    assign qstat.empty = (cnt_reg == '0);
    assign qstat.count = cnt_reg;

endmodule
`default_nettype wire

>>> rtl/core/qgpd_back.sv
// Back end: log2 gain, CORDIC phase and the result register.
`default_nettype none
module qgpd_back #(
    parameter int MAX_COUNT_BITS  = 16,
    parameter int CORDIC_STEPS    = 16,
    localparam int ACC_W          = MAX_COUNT_BITS + 32,
    localparam int SNAP_W         = 6 * ACC_W + 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire qgpd_pkg::queue_status_t   qstat,
    input  wire logic [SNAP_W-1:0]         snap_data,
    output logic                           snap_pop,
    input  wire logic                      pop,
    output logic                           empty,
    output logic signed [15:0]             gain_db_q8,
    output logic signed [15:0]             phase_deg_q7,
    output logic                           no_input,
    output logic                           overflow
);

    localparam int SW    = $clog2(ACC_W);
    localparam int LOG_W = SW + qgpd_pkg::LOG_FRAC_BITS;
    localparam int GP_W  = LOG_W + 20;
    localparam int CW    = ACC_W + 2;
    localparam int IW    = $clog2(CORDIC_STEPS);
    localparam int PP_W  = 51;
    localparam logic signed [GP_W-1:0] G_RND = GP_W'(1) << 23;
    localparam logic signed [PP_W-1:0] P_RND = PP_W'(1) << 31;

    qgpd_pkg::back_state_t state_reg, state_next;

    logic [ACC_W-1:0]        re_reg, de_reg, re_next, de_next;
    logic signed [ACC_W-1:0] ri_reg, rq_reg, di_reg, dq_reg;
    logic signed [ACC_W-1:0] ri_next, rq_next, di_next, dq_next;
    logic                    ovf_reg, ovf_next, noin_reg, noin_next, sel_reg, sel_next;
    logic [ACC_W-1:0]        w_reg, w_next;
    logic [SW-1:0]           s_reg, s_next;
    logic [30:0]             m_reg, m_next;
    logic [15:0]             frac_reg, frac_next;
    logic [3:0]              it_reg, it_next;
    logic [LOG_W-1:0]        logd_reg, logd_next, logr_reg, logr_next;
    logic signed [CW-1:0]    x_reg, y_reg, x_next, y_next;
    logic [31:0]             z_reg, z_next, zd_reg, zd_next;
    logic [IW-1:0]           i_reg, i_next;
    logic signed [GP_W-1:0]  gp_reg, gp_next;
    logic signed [15:0]      gain_reg, gain_next;
    logic signed [PP_W-1:0]  pp_reg, pp_next;
    logic                    ov_reg, ov_next;
    logic signed [15:0]      og_reg, og_next, op_reg, op_next;
    logic                    on_reg, on_next, oo_reg, oo_next;

    logic [61:0]             sq;
    logic [31:0]             msq;
    logic [15:0]             frac_new;
    logic [LOG_W-1:0]        log_new;
    logic signed [LOG_W:0]   ldiff;
    logic signed [GP_W-1:0]  gq;
    logic signed [ACC_W-1:0] vx, vy;
    logic signed [CW-1:0]    xs, ys;
    logic [31:0]             at, diff;
    logic signed [32:0]      ang;
    logic                    vec_zero, out_free, last_sq, last_it;

    assign sq       = m_reg * m_reg;
    assign msq      = sq[61:30];
    assign frac_new = {frac_reg[14:0], msq[31]};
    assign log_new  = {SW'(ACC_W - 1) - s_reg, frac_new};
    assign last_sq  = (it_reg == 4'(qgpd_pkg::LOG_FRAC_BITS - 1));
    assign vx       = sel_reg ? ri_reg : di_reg;
    assign vy       = sel_reg ? rq_reg : dq_reg;
    assign vec_zero = (vx == '0) && (vy == '0);
    assign xs       = x_reg >>> i_reg;
    assign ys       = y_reg >>> i_reg;
    assign at       = qgpd_pkg::ATAN_TURNS[5'(i_reg)];
    assign last_it  = (i_reg == IW'(CORDIC_STEPS - 1));
    assign ldiff    = $signed({1'b0, logd_reg}) - $signed({1'b0, logr_reg});
    assign gq       = gp_reg >>> 24;
    assign diff     = zd_reg - z_reg;
    assign ang      = (diff > 32'h80000000) ? $signed({1'b1, diff}) : $signed({1'b0, diff});
    assign out_free = ~ov_reg | pop;
    assign snap_pop = (state_reg == qgpd_pkg::B_IDLE) & ~qstat.empty;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            qgpd_pkg::B_IDLE:   if (!qstat.empty) state_next = qgpd_pkg::B_START;
            qgpd_pkg::B_START:
                state_next = ((re_reg == '0) || (de_reg == '0)) ? qgpd_pkg::B_CPREP
                                                                 : qgpd_pkg::B_NORM;
            qgpd_pkg::B_NORM:   if (w_reg[ACC_W-1]) state_next = qgpd_pkg::B_SQUARE;
            qgpd_pkg::B_SQUARE:
                if (last_sq) state_next = sel_reg ? qgpd_pkg::B_GAIN : qgpd_pkg::B_NORM;
            qgpd_pkg::B_GAIN:   state_next = qgpd_pkg::B_GSAT;
            qgpd_pkg::B_GSAT:   state_next = qgpd_pkg::B_CPREP;
            qgpd_pkg::B_CPREP:
                state_next = vec_zero ? qgpd_pkg::B_CEND : qgpd_pkg::B_CITER;
            qgpd_pkg::B_CITER:  if (last_it) state_next = qgpd_pkg::B_CEND;
            qgpd_pkg::B_CEND:
                state_next = sel_reg ? qgpd_pkg::B_PHASE : qgpd_pkg::B_CPREP;
            qgpd_pkg::B_PHASE:  state_next = qgpd_pkg::B_PFIN;
            qgpd_pkg::B_PFIN:   state_next = qgpd_pkg::B_DONE;
            qgpd_pkg::B_DONE:   if (out_free) state_next = qgpd_pkg::B_IDLE;
            default:            state_next = qgpd_pkg::B_IDLE;
        endcase
    end

    // Datapath.
    always_comb begin
        re_next = re_reg;   de_next = de_reg;
        ri_next = ri_reg;   rq_next = rq_reg;
        di_next = di_reg;   dq_next = dq_reg;
        ovf_next = ovf_reg; noin_next = noin_reg; sel_next = sel_reg;
        w_next = w_reg;     s_next = s_reg;       m_next = m_reg;
        frac_next = frac_reg; it_next = it_reg;
        logd_next = logd_reg; logr_next = logr_reg;
        x_next = x_reg;     y_next = y_reg;       z_next = z_reg;
        zd_next = zd_reg;   i_next = i_reg;
        gp_next = gp_reg;   gain_next = gain_reg; pp_next = pp_reg;
        og_next = og_reg;   op_next = op_reg;     on_next = on_reg; oo_next = oo_reg;
        ov_next = ov_reg & ~pop;
        case (state_reg)
            qgpd_pkg::B_IDLE: begin
                if (!qstat.empty) begin
                    {ovf_next, re_next, de_next, ri_next, rq_next, di_next, dq_next} =
                        snap_data;
                end
            end
            qgpd_pkg::B_START: begin
                noin_next = (re_reg == '0);
                sel_next  = 1'b0;
                w_next    = de_reg;
                s_next    = '0;
                gain_next = -16'(qgpd_pkg::GAIN_MAX_Q8);
            end
            qgpd_pkg::B_NORM: begin
                if (w_reg[ACC_W-1]) begin
                    m_next    = w_reg[ACC_W-1 -: 31];
                    frac_next = '0;
                    it_next   = '0;
                end else begin
                    w_next = w_reg << 1;
                    s_next = s_reg + SW'(1);
                end
            end
            qgpd_pkg::B_SQUARE: begin
                m_next    = msq[31] ? msq[31:1] : msq[30:0];
                frac_next = frac_new;
                it_next   = it_reg + 4'd1;
                if (last_sq) begin
                    if (sel_reg) begin
                        logr_next = log_new;
                    end else begin
                        logd_next = log_new;
                        sel_next  = 1'b1;
                        w_next    = re_reg;
                        s_next    = '0;
                    end
                end
            end
            qgpd_pkg::B_GAIN: begin
                gp_next = GP_W'(ldiff) * GP_W'(qgpd_pkg::LOG_SCALE) + G_RND;
            end
            qgpd_pkg::B_GSAT: begin
                sel_next = 1'b0;
                if (gq > GP_W'(qgpd_pkg::GAIN_MAX_Q8)) begin
                    gain_next = 16'(qgpd_pkg::GAIN_MAX_Q8);
                end else if (gq < -GP_W'(qgpd_pkg::GAIN_MAX_Q8)) begin
                    gain_next = -16'(qgpd_pkg::GAIN_MAX_Q8);
                end else begin
                    gain_next = gq[15:0];
                end
            end
            qgpd_pkg::B_CPREP: begin
                i_next = '0;
                if (vec_zero) begin
                    z_next = '0;
                end else if (vx < 0) begin
                    x_next = -CW'(vx);
                    y_next = -CW'(vy);
                    z_next = 32'h80000000;
                end else begin
                    x_next = CW'(vx);
                    y_next = CW'(vy);
                    z_next = '0;
                end
            end
            qgpd_pkg::B_CITER: begin
                i_next = i_reg + IW'(1);
                if (y_reg > 0) begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + at;
                end else begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - at;
                end
            end
            qgpd_pkg::B_CEND: begin
                if (!sel_reg) begin
                    zd_next  = z_reg;
                    sel_next = 1'b1;
                end
            end
            qgpd_pkg::B_PHASE: begin
                pp_next = PP_W'(ang) * PP_W'(qgpd_pkg::PHASE_SCALE) + P_RND;
            end
            qgpd_pkg::B_DONE: begin
                // Load the result word only once the previous one has left.
                if (out_free) begin
                    og_next = gain_reg;
                    op_next = pp_reg[47:32];
                    on_next = noin_reg;
                    oo_next = ovf_reg;
                    ov_next = 1'b1;
                end
            end
            default: begin
                ov_next = ov_reg & ~pop;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= qgpd_pkg::B_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk) begin
        re_reg <= re_next;     de_reg <= de_next;
        ri_reg <= ri_next;     rq_reg <= rq_next;
        di_reg <= di_next;     dq_reg <= dq_next;
        ovf_reg <= ovf_next;   noin_reg <= noin_next; sel_reg <= sel_next;
        w_reg <= w_next;       s_reg <= s_next;       m_reg <= m_next;
        frac_reg <= frac_next; it_reg <= it_next;
        logd_reg <= logd_next; logr_reg <= logr_next;
        x_reg <= x_next;       y_reg <= y_next;       z_reg <= z_next;
        zd_reg <= zd_next;     i_reg <= i_next;
        gp_reg <= gp_next;     gain_reg <= gain_next; pp_reg <= pp_next;
        og_reg <= og_next;     op_reg <= op_next;     on_reg <= on_next; oo_reg <= oo_next;
    end

    assign empty        = ~ov_reg;
    assign gain_db_q8   = og_reg;
    assign phase_deg_q7 = op_reg;
    assign no_input     = on_reg;
    assign overflow     = oo_reg;

endmodule
`default_nettype wire

>>> rtl/core/quadrature_gain_phase_detector_unit.sv
// Top level of the quadrature gain and phase detector.
//
//   channel   | handshake          | words
//   ----------+--------------------+------------------------------------------
//   samples   | push / full        | ref_sample, dut_sample, last_sample
//   results   | pop / empty        | gain_db_q8, phase_deg_q7, no_input, overflow
//   config    | phase_step_we      | phase_step_wdata
//
// Samples enter one per cycle while full is low, through a three-stage front
// (table read, products, accumulate). A word marked last hands the six sums
// to a two-entry queue; the back end takes one block at a time, with a
// one-bit normalize shift, a shared log squarer and a shared CORDIC. full
// rises while two block ends are queued or in flight. Reset clears the
// oscillator, counters, sums and result valid flag at once.
`default_nettype none
module quadrature_gain_phase_detector_unit #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int MAX_COUNT_BITS  = 16,
    parameter int CORDIC_STEPS    = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [15:0] ref_sample,
    input  wire logic signed [15:0] dut_sample,
    input  wire logic               last_sample,
    input  wire logic               pop,
    output logic                    empty,
    output logic signed [15:0]      gain_db_q8,
    output logic signed [15:0]      phase_deg_q7,
    output logic                    no_input,
    output logic                    overflow,
    input  wire logic               phase_step_we,
    input  wire logic [31:0]        phase_step_wdata
);

    localparam int ACC_W  = MAX_COUNT_BITS + 32;
    localparam int SNAP_W = 6 * ACC_W + 1;

    qgpd_pkg::queue_status_t qstat;
    logic                    snap_push, snap_pop;
    logic [SNAP_W-1:0]       snap_wdata, snap_rdata;

    // Front: intake, oscillator and correlation sums.
    qgpd_front #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .MAX_COUNT_BITS  (MAX_COUNT_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .ref_sample  (ref_sample),
        .dut_sample  (dut_sample),
        .last_sample (last_sample),
        .step_we     (phase_step_we),
        .step_wdata  (phase_step_wdata),
        .qstat       (qstat),
        .snap_push   (snap_push),
        .snap_data   (snap_wdata)
    );

    // Decouple the per-sample pipeline from the slow block math.
    qgpd_queue #(
        .WIDTH (SNAP_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (snap_push),
        .wr_data (snap_wdata),
        .rd_en   (snap_pop),
        .rd_data (snap_rdata),
        .qstat   (qstat)
    );

    // Back: gain and phase per block, then hold the result word.
    qgpd_back #(
        .MAX_COUNT_BITS (MAX_COUNT_BITS),
        .CORDIC_STEPS   (CORDIC_STEPS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (qstat),
        .snap_data    (snap_rdata),
        .snap_pop     (snap_pop),
        .pop          (pop),
        .empty        (empty),
        .gain_db_q8   (gain_db_q8),
        .phase_deg_q7 (phase_deg_q7),
        .no_input     (no_input),
        .overflow     (overflow)
    );

endmodule
`default_nettype wire

>>> rtl/core/qgpd_checker.sv
// Port checker of the detector and its bind to the top level.
`default_nettype none
`include "quadrature_gain_phase_detector_unit_defines.svh"
module qgpd_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               pop,
    input wire logic               empty,
    input wire logic signed [15:0] gain_db_q8,
    input wire logic signed [15:0] phase_deg_q7,
    input wire logic               no_input
);

    `QGPD_ASSERT_IMP(a_noin_gain, clk, rst_n, !empty && no_input, gain_db_q8 == -16'sd24576)
    `QGPD_ASSERT_IMP(a_gain_rng, clk, rst_n, !empty, gain_db_q8 <= 16'sd24576 && gain_db_q8 >= -16'sd24576)
    `QGPD_ASSERT_IMP(a_phase_rng, clk, rst_n, !empty, phase_deg_q7 <= 16'sd23040 && phase_deg_q7 >= -16'sd23040)
    `QGPD_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(gain_db_q8))

endmodule

bind quadrature_gain_phase_detector_unit qgpd_checker u_qgpd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop          (pop),
    .empty        (empty),
    .gain_db_q8   (gain_db_q8),
    .phase_deg_q7 (phase_deg_q7),
    .no_input     (no_input)
);
`default_nettype wire
